>>> src/crcfb_pkg.sv
// Package for the CRC-32 frame builder: types, constants, CRC table and helpers.
package crcfb_pkg;

   localparam int unsigned REQ_DATA_W = 56;
   localparam int unsigned RSP_DATA_W = 8;
   localparam int unsigned RSP_USER_W = 3;

   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0]  SOF_BYTE = 8'hA5;
   localparam logic [31:0] CRC_POLY = 32'hEDB88320;
   localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

   // item kind on the request tuser bit
   localparam logic REQ_START = 1'b0;
   localparam logic REQ_DATA  = 1'b1;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_SUBTYPE = 2'd1,
      STATUS_NOFRAME = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      CMD_START,
      CMD_DATA,
      CMD_ERR_SUB,
      CMD_ERR_NOFRAME
   } cmd_kind_type;

   // start: byte_a = msg_type, byte_b = subtype, word = payload_length
   // data:  byte_a = payload byte, word = payload CRC up to this byte (inverted), trailer
   typedef struct packed {
      cmd_kind_type kind;
      logic [7:0]   byte_a;
      logic [7:0]   byte_b;
      logic [31:0]  word;
      logic         trailer;
   } cmd_item_type;

   typedef logic [31:0] crc_tab_type [256];

   function automatic crc_tab_type gen_crc_table();
      crc_tab_type t;
      logic [31:0] c;
      for (int i = 0; i < 256; i++) begin
         c = 32'(i);
         for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
         end
         t[i] = c;
      end
      return t;
   endfunction

   localparam crc_tab_type CRC_TABLE = gen_crc_table();

   // one byte into a reflected CRC-32 register
   function automatic logic [31:0] crc_update(input logic [31:0] c, input logic [7:0] b);
      logic [7:0] idx;
      idx = c[7:0] ^ b;
      return CRC_TABLE[idx] ^ {8'h00, c[31:8]};
   endfunction

   // big-endian byte pick: index 0 is the most significant byte
   function automatic logic [7:0] be_byte(input logic [31:0] w, input logic [1:0] idx);
      logic [7:0] r;
      case (idx)
         2'd0:    r = w[31:24];
         2'd1:    r = w[23:16];
         2'd2:    r = w[15:8];
         default: r = w[7:0];
      endcase
      return r;
   endfunction

endpackage

>>> src/crcfb_front.sv
// Front end: accepts request transfers, tracks the open frame and the payload CRC.
module crcfb_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [crcfb_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  logic                                req_tuser,
   input  logic                                q_full,
   output logic                                q_push,
   output crcfb_pkg::cmd_item_type             q_wdata
);
   import crcfb_pkg::*;

   logic        frame_open_ff, frame_open_in;
   logic [31:0] bytes_left_ff, bytes_left_in;
   logic [31:0] payload_crc_ff, payload_crc_in;

   logic [7:0]  msg_type;
   logic [7:0]  frame_subtype;
   logic [31:0] payload_length;
   logic [7:0]  data_byte;
   logic [31:0] crc_next;
   logic        accept;

   assign msg_type       = req_tdata[7:0];
   assign frame_subtype  = req_tdata[15:8];
   assign payload_length = req_tdata[47:16];
   assign data_byte      = req_tdata[55:48];

   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;
   assign q_push     = accept;
   assign crc_next   = crc_update(payload_crc_ff, data_byte);

   always_comb begin
      frame_open_in   = frame_open_ff;
      bytes_left_in   = bytes_left_ff;
      payload_crc_in  = payload_crc_ff;
      q_wdata.kind    = CMD_START;
      q_wdata.byte_a  = msg_type;
      q_wdata.byte_b  = frame_subtype;
      q_wdata.word    = payload_length;
      q_wdata.trailer = 1'b0;
      if (req_tuser == REQ_START) begin
         // a start always abandons the open frame
         frame_open_in  = 1'b0;
         bytes_left_in  = '0;
         payload_crc_in = CRC_INIT;
         if (frame_subtype == 8'h00) begin
            q_wdata.kind = CMD_ERR_SUB;
         end else if (payload_length != 32'd0) begin
            frame_open_in = 1'b1;
            bytes_left_in = payload_length;
         end
      end else if (!frame_open_ff) begin
         q_wdata.kind = CMD_ERR_NOFRAME;
      end else begin
         q_wdata.kind   = CMD_DATA;
         q_wdata.byte_a = data_byte;
         q_wdata.word   = crc_next ^ CRC_INIT;
         payload_crc_in = crc_next;
         bytes_left_in  = bytes_left_ff - 32'd1;
         if (bytes_left_ff == 32'd1) begin
            q_wdata.trailer = 1'b1;
            frame_open_in   = 1'b0;
            bytes_left_in   = '0;
            payload_crc_in  = CRC_INIT;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_open_ff  <= 1'b0;
         bytes_left_ff  <= '0;
         payload_crc_ff <= CRC_INIT;
      end else if (accept) begin
         frame_open_ff  <= frame_open_in;
         bytes_left_ff  <= bytes_left_in;
         payload_crc_ff <= payload_crc_in;
      end
   end

   a_closed_no_count: assert property (@(posedge clock) disable iff (reset)
      !frame_open_ff |-> bytes_left_ff == 32'd0)
      else $error("bytes left while no frame is open");

   a_closed_crc_init: assert property (@(posedge clock) disable iff (reset)
      !frame_open_ff |-> payload_crc_ff == CRC_INIT)
      else $error("payload CRC not reinitialized on closed frame");

   a_last_closes: assert property (@(posedge clock) disable iff (reset)
      (q_push && q_wdata.kind == CMD_DATA && q_wdata.trailer) |=> !frame_open_ff)
      else $error("frame still open after last payload byte");

endmodule

>>> src/crcfb_queue.sv
// Short command queue between the front end and the back end.
module crcfb_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  crcfb_pkg::cmd_item_type wdata,
   output logic                    full,
   input  logic                    pop,
   output logic                    head_valid,
   output crcfb_pkg::cmd_item_type head
);
   import crcfb_pkg::*;

   cmd_item_type       mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wptr_ff, wptr_in;
   logic [QPTR_W-1:0]  rptr_ff, rptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;
   logic               do_pop;

   assign full       = count_ff == QCNT_W'(QUEUE_DEPTH);
   assign head_valid = count_ff != '0;
   assign head       = mem_ff[rptr_ff];
   assign do_pop     = pop && head_valid;

   always_comb begin
      wptr_in  = push ? QPTR_W'(wptr_ff + 1'b1) : wptr_ff;
      rptr_in  = do_pop ? QPTR_W'(rptr_ff + 1'b1) : rptr_ff;
      count_in = count_ff;
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wptr_ff] <= wdata;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("push into full queue");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("queue count out of range");

   a_ptr_match: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (wptr_ff == rptr_ff))
      else $error("pointers differ on empty queue");

endmodule

>>> src/crcfb_back.sv
// Back end: sequences header, payload, trailer and error bytes into the response register.
module crcfb_back (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                cmd_valid,
   input  crcfb_pkg::cmd_item_type             cmd,
   output logic                                cmd_pop,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [crcfb_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic                                rsp_tlast,
   output logic [crcfb_pkg::RSP_USER_W-1:0]    rsp_tuser
);
   import crcfb_pkg::*;

   localparam logic [3:0] STEP_HDR_LAST  = 4'd6;
   localparam logic [3:0] STEP_HCRC_LAST = 4'd10;
   localparam logic [3:0] STEP_TRL_LAST  = 4'd14;
   localparam logic [3:0] STEP_HCRC_BASE = 4'd7;
   localparam logic [3:0] STEP_DCRC_LAST = 4'd4;

   logic [3:0]  step_ff, step_in;
   logic [31:0] hcrc_ff, hcrc_in;
   logic        valid_ff, valid_in;
   logic [7:0]  byte_ff, byte_in;
   logic        last_ff, last_in;
   logic        fend_ff, fend_in;
   status_type  status_ff, status_in;
   logic        advance;
   logic [31:0] hcrc_fin;

   assign advance  = cmd_valid && (!valid_ff || rsp_tready);
   assign cmd_pop  = advance && last_in;
   assign hcrc_fin = hcrc_ff ^ CRC_INIT;

   always_comb begin
      byte_in   = 8'h00;
      last_in   = 1'b0;
      fend_in   = 1'b0;
      status_in = STATUS_OK;
      hcrc_in   = hcrc_ff;
      case (cmd.kind)
         CMD_START: begin
            case (step_ff)
               4'd0:    byte_in = SOF_BYTE;
               4'd1:    byte_in = cmd.byte_a;
               4'd2:    byte_in = cmd.word[31:24];
               4'd3:    byte_in = cmd.word[23:16];
               4'd4:    byte_in = cmd.word[15:8];
               4'd5:    byte_in = cmd.word[7:0];
               4'd6:    byte_in = cmd.byte_b;
               default: byte_in = 8'h00;
            endcase
            if (step_ff inside {[STEP_HCRC_BASE:STEP_HCRC_LAST]}) begin
               byte_in = be_byte(hcrc_fin, 2'(step_ff - STEP_HCRC_BASE));
            end
            if (step_ff <= STEP_HDR_LAST) begin
               hcrc_in = crc_update((step_ff == 4'd0) ? CRC_INIT : hcrc_ff, byte_in);
            end
            // zero-length frame: trailer is the CRC of no bytes, all zero
            last_in = (step_ff == STEP_HCRC_LAST && cmd.word != 32'd0) ||
                      step_ff == STEP_TRL_LAST;
            fend_in = step_ff == STEP_TRL_LAST;
         end
         CMD_DATA: begin
            if (step_ff == 4'd0) begin
               byte_in = cmd.byte_a;
               last_in = !cmd.trailer;
            end else begin
               byte_in = be_byte(cmd.word, 2'(step_ff - 4'd1));
               last_in = step_ff == STEP_DCRC_LAST;
               fend_in = step_ff == STEP_DCRC_LAST;
            end
         end
         CMD_ERR_SUB: begin
            status_in = STATUS_SUBTYPE;
            last_in   = 1'b1;
         end
         default: begin
            status_in = STATUS_NOFRAME;
            last_in   = 1'b1;
         end
      endcase
      step_in  = last_in ? 4'd0 : 4'(step_ff + 4'd1);
      valid_in = advance || (valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (advance) begin
            step_ff <= step_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         hcrc_ff   <= hcrc_in;
         byte_ff   <= byte_in;
         last_ff   <= last_in;
         fend_ff   <= fend_in;
         status_ff <= status_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = byte_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tuser  = {status_ff, fend_ff};

   a_fend_is_last: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && fend_ff) |-> last_ff)
      else $error("frame end not on last byte of transfer run");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && status_ff != STATUS_OK) |-> (last_ff && byte_ff == 8'h00 && !fend_ff))
      else $error("malformed error response");

   a_step_range: assert property (@(posedge clock) disable iff (reset)
      step_ff <= STEP_TRL_LAST)
      else $error("sequencer step out of range");

endmodule

>>> src/crc32_frame_builder_top.sv
// Top level of the CRC-32 frame builder: front end, command queue and back end.
//
//  channel   direction  tdata                                  tuser / tlast
//  req_      in         [7:0] msg_type [15:8] subtype           tuser: req_type
//                       [47:16] payload_length [55:48] data_byte
//  rsp_      out        [7:0] out_byte                          tuser: [0] frame_end
//                                                               [2:1] status; tlast: run_last
//
// The front end takes one request transfer per cycle while the 4-entry queue has room.
// The back end emits one response byte per cycle: a start gives 11 bytes (15 at length
// zero), a payload byte 1 (5 with the trailer), an error 1; the output port sets the rate.
// A request is written into the queue, then into the output register, before its first
// response byte is valid; payload streams one byte per cycle while the port is ready.
// Reset is synchronous, active high, and clears frame state, queue and output valid.
// A stalled response holds in the output register while the queue keeps filling.
module crc32_frame_builder_top (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [crcfb_pkg::REQ_DATA_W-1:0] req_tdata,  // msg_type subtype payload_length data_byte
   input  logic                             req_tuser,  // req_type
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [crcfb_pkg::RSP_DATA_W-1:0] rsp_tdata,  // out_byte
   output logic                             rsp_tlast,
   output logic [crcfb_pkg::RSP_USER_W-1:0] rsp_tuser   // frame_end, status
);
   import crcfb_pkg::*;

   logic         q_full;
   logic         q_push;
   cmd_item_type q_wdata;
   logic         q_pop;
   logic         q_head_valid;
   cmd_item_type q_head;

   crcfb_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_wdata    (q_wdata)
   );

   crcfb_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .wdata      (q_wdata),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_head_valid),
      .head       (q_head)
   );

   crcfb_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (q_head_valid),
      .cmd        (q_head),
      .cmd_pop    (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
